// File: sv/isrt_pkg.sv
// Shared types and constants for the insertion sorter.
package isrt_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the new value, larger entries move one cell right
    logic unl;  // unload: every cell takes its right neighbor's entry
  } cell_ctl_t;

endpackage

// File: sv/isrt_cell.sv
// One cell of the sorting chain: holds one entry and its valid bit.
module isrt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  isrt_pkg::cell_ctl_t ctl,
  input  isrt_pkg::value_t   new_value,
  input  isrt_pkg::value_t   left_value,
  input  logic               left_valid,
  input  logic               left_take,
  input  isrt_pkg::value_t   right_value,
  input  logic               right_valid,
  output isrt_pkg::value_t   value,
  output logic               valid,
  output logic               take
);
  import isrt_pkg::*;

  value_t value_r, value_nxt;
  logic   valid_r, valid_nxt;

  // Empty cells and cells holding a larger entry give way to the new value.
  assign take = !valid_r || (value_r > new_value);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.ins && take) begin
      value_nxt = left_take ? left_value : new_value;
      valid_nxt = left_valid;
    end else if (ctl.unl) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

// File: sv/insertion_sorter.sv
// Top level of the insertion sorter: a chain of sorting cells and its control.
//
// Input channel (in_valid/in_ready): one signed value per item; in_last_item
// closes the set. Each value goes straight into the cell chain: every cell
// compares against the broadcast value at once and the larger entries move
// one cell right, so the block takes one item per cycle while loading.
// A value arriving while all CAPACITY cells are full is dropped and the
// overflow flag is raised for the current set.
// After the item marked last is accepted, the chain unloads: the result
// channel (out_valid/out_ready) shows the head cell from the next cycle on,
// and each accepted result shifts the chain one cell left, so the set leaves
// in ascending order as the receiver takes the results. out_last_result
// marks the largest value; out_overflow is constant over the run.
// While unloading, in_ready is low; a stalled receiver simply holds the
// chain. Taking the final result clears the overflow flag and reopens input.
// Reset empties the chain and clears the flag.
module insertion_sorter #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  isrt_pkg::value_t in_value,
  input  logic             in_last_item,
  output logic             out_valid,
  input  logic             out_ready,
  output isrt_pkg::value_t out_sorted_value,
  output logic             out_last_result,
  output logic             out_overflow
);
  import isrt_pkg::*;

  value_t    cell_val  [CAPACITY];
  logic      cell_vld  [CAPACITY];
  logic      cell_take [CAPACITY];
  cell_ctl_t ctl;

  logic unloading_r, unloading_nxt;
  logic dropped_r, dropped_nxt;
  logic in_acc, out_acc, full;

  assign full    = cell_vld[CAPACITY-1];
  assign in_ready = !unloading_r;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign ctl = '{ins: in_acc && !full, unl: out_acc};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t l_val, r_val;
    logic   l_vld, l_take, r_vld;

    if (i == 0) begin : g_head
      assign l_val  = in_value;
      assign l_vld  = 1'b1;
      assign l_take = 1'b0;
    end else begin : g_mid
      assign l_val  = cell_val[i-1];
      assign l_vld  = cell_vld[i-1];
      assign l_take = cell_take[i-1];
    end

    if (i == CAPACITY-1) begin : g_tail
      assign r_val = cell_val[i];
      assign r_vld = 1'b0;
    end else begin : g_inner
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
    end

    isrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_value  (in_value),
      .left_value (l_val),
      .left_valid (l_vld),
      .left_take  (l_take),
      .right_value(r_val),
      .right_valid(r_vld),
      .value      (cell_val[i]),
      .valid      (cell_vld[i]),
      .take       (cell_take[i])
    );
  end

  always_comb begin
    unloading_nxt = unloading_r;
    dropped_nxt   = dropped_r;
    if (in_acc) begin
      if (full) dropped_nxt = 1'b1;
      if (in_last_item) unloading_nxt = 1'b1;
    end
    if (out_acc && out_last_result) begin
      unloading_nxt = 1'b0;
      dropped_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unloading_r <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      unloading_r <= unloading_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

  // Results come straight from the head cell; the second cell tells the end.
  assign out_valid        = unloading_r && cell_vld[0];
  assign out_sorted_value = cell_val[0];
  assign out_last_result  = (CAPACITY > 1) ? !cell_vld[1 % CAPACITY] : 1'b1;
  assign out_overflow     = dropped_r;

endmodule

// File: sv/isrt_checker.sv
// Port-level checker for the insertion sorter and its bind.
module isrt_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input isrt_pkg::value_t in_value,
  input logic             in_last_item,
  input logic             out_valid,
  input logic             out_ready,
  input isrt_pkg::value_t out_sorted_value,
  input logic             out_last_result,
  input logic             out_overflow
);
  import isrt_pkg::*;

  // Input is closed whenever a result is shown.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while results pending");

  // The item closing a set starts the output run on the next cycle.
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_item) |=> out_valid)
    else $error("no result after last item");

  // Taking the final result reopens the input.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_result) |=> (in_ready && !out_valid))
    else $error("input not reopened after final result");

  // Within a run, successive results ascend and carry the same overflow flag.
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_result) |=>
      (out_valid && (out_sorted_value >= $past(out_sorted_value))
       && (out_overflow == $past(out_overflow))))
    else $error("run out of order or overflow changed");

endmodule

bind insertion_sorter isrt_checker u_isrt_checker (.*);

// File: test/insertion_sorter_checker.sv
// Checker for the insertion sorter: predicts each sorted run and compares it with the outputs.
module insertion_sorter_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  isrt_pkg::value_t in_value,
  input  logic             in_last_item,
  input  logic             out_valid,
  input  logic             out_ready,
  input  isrt_pkg::value_t out_sorted_value,
  input  logic             out_last_result,
  input  logic             out_overflow,
  output int               errors,
  output int               pending,
  output int               items_seen,
  output int               sets_seen,
  output int               results_seen,
  output int               overflow_sets
);
  timeunit 1ns;
  timeprecision 1ps;

  import isrt_pkg::*;

  typedef struct {
    value_t sval;
    logic   fin;
    logic   ovf;
  } sorted_result_t;

  value_t         held_q[$];
  logic           set_dropped = 1'b0;
  sorted_result_t sorted_results_q[$];

  initial begin
    errors        = 0;
    pending       = 0;
    items_seen    = 0;
    sets_seen     = 0;
    results_seen  = 0;
    overflow_sets = 0;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 30) $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Insert after every held value not greater than v; a full store drops v.
  task automatic insert_and_flush(input value_t v, input logic fin);
    int             pos;
    sorted_result_t res;
    items_seen++;
    if (held_q.size() >= CAPACITY) begin
      set_dropped = 1'b1;
    end else begin
      pos = 0;
      while (pos < held_q.size() && held_q[pos] <= v) pos++;
      held_q.insert(pos, v);
    end
    if (fin) begin
      for (int k = 0; k < held_q.size(); k++) begin
        res.sval = held_q[k];
        res.fin  = (k == held_q.size() - 1);
        res.ovf  = set_dropped;
        sorted_results_q.push_back(res);
      end
      sets_seen++;
      if (set_dropped) overflow_sets++;
      held_q.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic check_result();
    sorted_result_t res;
    if (sorted_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected item, value %0d", out_sorted_value));
    end else begin
      res = sorted_results_q.pop_front();
      results_seen++;
      if (out_sorted_value !== res.sval)
        report_mismatch($sformatf("sorted_value %0d, want %0d", out_sorted_value, res.sval));
      if (out_last_result !== res.fin)
        report_mismatch($sformatf("last_result %b, want %b (value %0d)",
                                  out_last_result, res.fin, res.sval));
      if (out_overflow !== res.ovf)
        report_mismatch($sformatf("overflow %b, want %b (value %0d)",
                                  out_overflow, res.ovf, res.sval));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) insert_and_flush(in_value, in_last_item);
      if (out_valid && out_ready) check_result();
    end
    pending <= sorted_results_q.size();
  end

endmodule

// File: test/insertion_sorter_tb.sv
// Testbench top for the insertion sorter: stimulus, pacing and verdict.
module insertion_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import isrt_pkg::*;

  localparam int unsigned CAPACITY        = 16;
  localparam int          ITEMS_PER_PHASE = 68;
  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          DRAIN_CYCLES    = 2 * CAPACITY + 8;

  localparam value_t VAL_MIN = value_t'(32'h8000_0000);
  localparam value_t VAL_MAX = value_t'(32'h7fff_ffff);

  logic   clk          = 1'b0;
  logic   rst_n        = 1'b0;
  logic   in_valid     = 1'b0;
  logic   in_ready;
  value_t in_value     = '0;
  logic   in_last_item = 1'b0;
  logic   out_valid;
  logic   out_ready    = 1'b0;
  value_t out_sorted_value;
  logic   out_last_result;
  logic   out_overflow;

  int errors, pending, items_seen, sets_seen, results_seen, overflow_sets;
  int cycles    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;

  // pacing per phase: free-running, sender idle, receiver stall, both
  int idle_tab[4]  = '{0, 66, 0, 17};
  int stall_tab[4] = '{0, 0, 66, 17};

  initial forever #5 clk = ~clk;

  insertion_sorter #(.CAPACITY(CAPACITY)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_result  (out_last_result),
    .out_overflow     (out_overflow)
  );

  insertion_sorter_checker #(.CAPACITY(CAPACITY)) sort_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sorted_value (out_sorted_value),
    .out_last_result  (out_last_result),
    .out_overflow     (out_overflow),
    .errors           (errors),
    .pending          (pending),
    .items_seen       (items_seen),
    .sets_seen        (sets_seen),
    .results_seen     (results_seen),
    .overflow_sets    (overflow_sets)
  );

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mix of full-range values, a narrow band that forces ties, and corners.
  function automatic value_t pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return value_t'($urandom);
    if (r < 75) return value_t'(int'($urandom_range(15)) - 8);
    case ($urandom_range(5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return value_t'(0);
      3:       return value_t'(-1);
      4:       return VAL_MIN + 1;
      default: return VAL_MAX - 1;
    endcase
  endfunction

  // Mostly short sets, some full ones, a few that overrun the store.
  function automatic int pick_set_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 1;
    if (r < 70) return $urandom_range(8, 2);
    if (r < 85) return $urandom_range(CAPACITY, 9);
    return $urandom_range(CAPACITY + 4, CAPACITY + 1);
  endfunction

  task automatic send_item(input value_t v, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_value     <= v;
    in_last_item <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  initial begin
    value_t corner_vals[7];
    int     phase_items;
    int     n;

    corner_vals = '{VAL_MAX, VAL_MIN, 0, -1, 5, 5, VAL_MIN};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, ties, a new minimum at the front, a tie with the minimum
    for (int i = 0; i < 7; i++) send_item(corner_vals[i], i == 6);
    // one-item set
    send_item(value_t'(-7), 1'b1);
    // descending set that overfills the store; the item marked last is dropped
    for (int i = 0; i <= CAPACITY; i++) send_item(value_t'(1000 - 3 * i), i == CAPACITY);

    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_tab[p];
      stall_pct  <= stall_tab[p];
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        n = pick_set_size();
        send_set(n);
        phase_items += n;
      end
    end
    in_valid <= 1'b0;
    // let the checker publish the count for the final set first
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items in %0d sets; %0d sorted results compared", items_seen, sets_seen,
             results_seen);
    $display("%0d sets overran the %0d-entry store; four pacing phases from free-run to stalls",
             overflow_sets, CAPACITY);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
